// ----- hw/rtl/rdz_pkg.sv -----
// Shared types, constants and helpers for the radial dead-zone stick block.
package rdz_pkg;

   localparam int SAMPLE_BITS_DEF = 16;
   localparam int FIELD_W         = 16;
   localparam int DZ_W            = 15;
   localparam logic [DZ_W-1:0] DZ_RESET = 15'd7849;

   // Magnitude carries 8 fraction bits; results are Q1.15.
   localparam int MAG_FRAC  = 8;
   localparam int FRAC_BITS = 15;
   // Quotient bits per divider: results never exceed 1.0, so 17 bits suffice.
   localparam int Q_W       = FRAC_BITS + 2;

   localparam int LANES    = 3;
   localparam int LANE_X   = 0;
   localparam int LANE_Y   = 1;
   localparam int LANE_MAG = 2;

   localparam logic [Q_W-1:0]     DIR_POS_MAX = 17'd32767;
   localparam logic [Q_W-1:0]     DIR_NEG_MAX = 17'd32768;
   localparam logic [Q_W-1:0]     MAG_ONE_Q   = 17'd32768;
   localparam logic [FIELD_W-1:0] MAG_ONE     = 16'd32768;

   typedef struct packed {
      logic signed [FIELD_W-1:0] stick_x;
      logic signed [FIELD_W-1:0] stick_y;
   } req_type;

   typedef struct packed {
      logic signed [FIELD_W-1:0] direction_x;
      logic signed [FIELD_W-1:0] direction_y;
      logic        [FIELD_W-1:0] scaled_magnitude;
      logic                      outside_zone;
   } rsp_type;

   // Apply sign and saturate a direction quotient to Q1.15.
   function automatic logic [FIELD_W-1:0] sat_dir(input logic neg, input logic [Q_W-1:0] q);
      logic [Q_W-1:0] nq;
      begin
         nq = ~q + 1'b1;
         if (neg) begin
            sat_dir = (q > DIR_NEG_MAX) ? DIR_NEG_MAX[FIELD_W-1:0] : nq[FIELD_W-1:0];
         end else begin
            sat_dir = (q > DIR_POS_MAX) ? DIR_POS_MAX[FIELD_W-1:0] : q[FIELD_W-1:0];
         end
      end
   endfunction

endpackage

// ----- hw/rtl/radial_dead_zone_stick.sv -----
// Top level: circular dead zone, unit direction and scaled deflection for one stick sample.
// A sample is taken in every cycle (busy stays low) and its result appears on rsp_data
// with rsp_valid high after the sign-removal, squaring and zone-test registers, one
// cell per root bit of the SAMPLE_BITS+8 bit square-root chain, the set-up register,
// 17 divider cells shared by the three quotients, and the output register. The result
// is not held: it must be taken in the cycle it is shown. Write csr_wdata (dead zone)
// only when no transaction is in flight.
module radial_dead_zone_stick #(
   parameter int SAMPLE_BITS = rdz_pkg::SAMPLE_BITS_DEF
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   output logic                        busy,
   input  rdz_pkg::req_type            req_data,
   output logic                        rsp_valid,
   output rdz_pkg::rsp_type            rsp_data,
   input  logic                        csr_we,
   input  logic [rdz_pkg::DZ_W-1:0]    csr_wdata
);
   import rdz_pkg::*;

   localparam int SB     = SAMPLE_BITS;
   localparam int SQ_W   = 2 * SB;
   localparam int RAD_W  = SQ_W + 2 * MAG_FRAC;
   localparam int ROOT_W = SB + MAG_FRAC;
   localparam int REM_W  = ROOT_W + 2;
   localparam int DIV_W  = ROOT_W + 1;
   localparam int NUM_W  = SB + MAG_FRAC + FRAC_BITS + 2 + 1;
   localparam int SIDE_S = 2 * SB + 3;
   localparam int SIDE_D = 4;
   localparam int FS     = (1 << (SB - 1)) - 1;
   localparam int LAT    = 3 + ROOT_W + 1 + Q_W + 1;

   // csr
   logic [DZ_W-1:0]   dead_zone_ff;
   logic [2*DZ_W-1:0] dz_sq_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         dead_zone_ff <= DZ_RESET;
      end else if (csr_we) begin
         dead_zone_ff <= csr_wdata;
      end
      dz_sq_ff <= dead_zone_ff * dead_zone_ff;
   end

   assign busy = 1'b0;

   // stage 0: magnitudes and signs
   logic [SB-1:0] xr, yr, ax_in, ay_in;
   logic [SB-1:0] ax_ff, ay_ff;
   logic          sx_ff, sy_ff, v0_ff;

   always_comb begin
      xr    = req_data.stick_x[SB-1:0];
      yr    = req_data.stick_y[SB-1:0];
      ax_in = xr[SB-1] ? (~xr + 1'b1) : xr;
      ay_in = yr[SB-1] ? (~yr + 1'b1) : yr;
   end

   // stage 1: squares
   logic [SQ_W-1:0] x2_ff, y2_ff;
   logic [SB-1:0]   ax1_ff, ay1_ff;
   logic            sx1_ff, sy1_ff, v1_ff;

   // stage 2: sum and exact zone test
   logic [SQ_W-1:0] s_in;
   logic [SQ_W-1:0] s_ff;
   logic [SB-1:0]   ax2_ff, ay2_ff;
   logic            sx2_ff, sy2_ff, out2_ff, v2_ff;

   assign s_in = x2_ff + y2_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v0_ff <= 1'b0;
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
      end else begin
         v0_ff <= start && !busy;
         v1_ff <= v0_ff;
         v2_ff <= v1_ff;
      end
      ax_ff   <= ax_in;
      ay_ff   <= ay_in;
      sx_ff   <= xr[SB-1];
      sy_ff   <= yr[SB-1];
      x2_ff   <= SQ_W'(ax_ff * ax_ff);
      y2_ff   <= SQ_W'(ay_ff * ay_ff);
      ax1_ff  <= ax_ff;
      ay1_ff  <= ay_ff;
      sx1_ff  <= sx_ff;
      sy1_ff  <= sy_ff;
      s_ff    <= s_in;
      out2_ff <= 33'(s_in) > 33'(dz_sq_ff);
      ax2_ff  <= ax1_ff;
      ay2_ff  <= ay1_ff;
      sx2_ff  <= sx1_ff;
      sy2_ff  <= sy1_ff;
   end

   // square-root chain, one root bit per cell
   logic                sv    [ROOT_W+1];
   logic [REM_W-1:0]    srem  [ROOT_W+1];
   logic [ROOT_W-1:0]   sroot [ROOT_W+1];
   logic [RAD_W-1:0]    srad  [ROOT_W+1];
   logic [SIDE_S-1:0]   sside [ROOT_W+1];

   assign sv[0]    = v2_ff;
   assign srem[0]  = '0;
   assign sroot[0] = '0;
   assign srad[0]  = {s_ff, {(2*MAG_FRAC){1'b0}}};
   assign sside[0] = {ax2_ff, ay2_ff, sx2_ff, sy2_ff, out2_ff};

   for (genvar k = 0; k < ROOT_W; k++) begin : g_sqrt
      rdz_sqrt_cell #(.ROOT_W(ROOT_W), .RAD_W(RAD_W), .SIDE_W(SIDE_S)) u_cell (
         .clock   (clock),
         .reset   (reset),
         .valid_i (sv[k]),
         .rem_i   (srem[k]),
         .root_i  (sroot[k]),
         .rad_i   (srad[k]),
         .side_i  (sside[k]),
         .valid_o (sv[k+1]),
         .rem_o   (srem[k+1]),
         .root_o  (sroot[k+1]),
         .rad_o   (srad[k+1]),
         .side_o  (sside[k+1])
      );
   end

   // divider set-up
   logic [ROOT_W-1:0] m;
   logic [SB-1:0]     pax, pay;
   logic              psx, psy, pout, full;
   logic [ROOT_W-1:0] mc;
   logic [NUM_W-1:0]  mag_num, mag_den;
   logic [LANES-1:0][NUM_W-1:0] nn;
   logic [LANES-1:0][DIV_W-1:0] rem0_in, den0_in;
   logic [LANES-1:0][Q_W-1:0]   nlow0_in;

   always_comb begin
      m = sroot[ROOT_W];
      {pax, pay, psx, psy, pout} = sside[ROOT_W];
      full = (DZ_W+1)'(dead_zone_ff) >= (DZ_W+1)'(FS);
      mc   = (m > ROOT_W'(FS << MAG_FRAC)) ? ROOT_W'(FS << MAG_FRAC) : m;
      mag_num = NUM_W'(mc) - (NUM_W'(dead_zone_ff) << MAG_FRAC);
      mag_den = (NUM_W'(FS) - NUM_W'(dead_zone_ff)) << MAG_FRAC;
      nn[LANE_X]   = (NUM_W'(pax) << (FRAC_BITS + 1 + MAG_FRAC)) + NUM_W'(m);
      nn[LANE_Y]   = (NUM_W'(pay) << (FRAC_BITS + 1 + MAG_FRAC)) + NUM_W'(m);
      nn[LANE_MAG] = (mag_num << (FRAC_BITS + 1)) + mag_den;
      den0_in[LANE_X]   = {m, 1'b0};
      den0_in[LANE_Y]   = {m, 1'b0};
      den0_in[LANE_MAG] = DIV_W'(mag_den << 1);
      // no usable range: keep the lane harmless, result forced later
      if (full) begin
         nn[LANE_MAG]      = '0;
         den0_in[LANE_MAG] = DIV_W'(2);
      end
      for (int l = 0; l < LANES; l++) begin
         rem0_in[l]  = DIV_W'(nn[l] >> Q_W);
         nlow0_in[l] = nn[l][Q_W-1:0];
      end
   end

   logic                        pv_ff;
   logic [LANES-1:0][DIV_W-1:0] prem_ff, pden_ff;
   logic [LANES-1:0][Q_W-1:0]   pnlow_ff;
   logic [SIDE_D-1:0]           pside_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         pv_ff <= 1'b0;
      end else begin
         pv_ff <= sv[ROOT_W];
      end
      prem_ff  <= rem0_in;
      pden_ff  <= den0_in;
      pnlow_ff <= nlow0_in;
      pside_ff <= {psx, psy, pout, full};
   end

   // divider chain, one quotient bit per cell, three lanes
   logic                        dv    [Q_W+1];
   logic [LANES-1:0][DIV_W-1:0] drem  [Q_W+1];
   logic [LANES-1:0][DIV_W-1:0] dden  [Q_W+1];
   logic [LANES-1:0][Q_W-1:0]   dnlow [Q_W+1];
   logic [LANES-1:0][Q_W-1:0]   dquo  [Q_W+1];
   logic [SIDE_D-1:0]           dside [Q_W+1];

   assign dv[0]    = pv_ff;
   assign drem[0]  = prem_ff;
   assign dden[0]  = pden_ff;
   assign dnlow[0] = pnlow_ff;
   assign dquo[0]  = '0;
   assign dside[0] = pside_ff;

   for (genvar k = 0; k < Q_W; k++) begin : g_div
      rdz_div_cell #(.DIV_W(DIV_W), .SIDE_W(SIDE_D)) u_cell (
         .clock   (clock),
         .reset   (reset),
         .valid_i (dv[k]),
         .rem_i   (drem[k]),
         .den_i   (dden[k]),
         .nlow_i  (dnlow[k]),
         .quo_i   (dquo[k]),
         .side_i  (dside[k]),
         .valid_o (dv[k+1]),
         .rem_o   (drem[k+1]),
         .den_o   (dden[k+1]),
         .nlow_o  (dnlow[k+1]),
         .quo_o   (dquo[k+1]),
         .side_o  (dside[k+1])
      );
   end

   // output register
   logic    fsx, fsy, fout, ffull;
   rsp_type rsp_in, rsp_ff;
   logic    rv_ff;

   always_comb begin
      {fsx, fsy, fout, ffull} = dside[Q_W];
      rsp_in = '0;
      if (fout) begin
         rsp_in.direction_x  = sat_dir(fsx, dquo[Q_W][LANE_X]);
         rsp_in.direction_y  = sat_dir(fsy, dquo[Q_W][LANE_Y]);
         rsp_in.outside_zone = 1'b1;
         if (ffull || dquo[Q_W][LANE_MAG] > MAG_ONE_Q) begin
            rsp_in.scaled_magnitude = MAG_ONE;
         end else begin
            rsp_in.scaled_magnitude = dquo[Q_W][LANE_MAG][FIELD_W-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rv_ff <= 1'b0;
      end else begin
         rv_ff <= dv[Q_W];
      end
      rsp_ff <= rsp_in;
   end

   assign rsp_valid = rv_ff;
   assign rsp_data  = rsp_ff;

   // checks
   a_latency: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |-> ##LAT rsp_valid)
      else $error("transaction result missing at expected latency");

   a_no_spurious: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(start && !busy, LAT))
      else $error("result without an accepted transaction");

   a_inside_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_data.outside_zone) |->
         (rsp_data.direction_x == '0 && rsp_data.direction_y == '0 &&
          rsp_data.scaled_magnitude == '0))
      else $error("non-zero result inside dead zone");

   a_mag_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_data.scaled_magnitude <= MAG_ONE))
      else $error("scaled magnitude above one");
endmodule

// ----- hw/rtl/rdz_sqrt_cell.sv -----
// One digit cell of the pipelined square-root chain.
module rdz_sqrt_cell #(
   parameter int ROOT_W = 24,
   parameter int RAD_W  = 48,
   parameter int SIDE_W = 35
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                valid_i,
   input  logic [ROOT_W+1:0]   rem_i,
   input  logic [ROOT_W-1:0]   root_i,
   input  logic [RAD_W-1:0]    rad_i,
   input  logic [SIDE_W-1:0]   side_i,
   output logic                valid_o,
   output logic [ROOT_W+1:0]   rem_o,
   output logic [ROOT_W-1:0]   root_o,
   output logic [RAD_W-1:0]    rad_o,
   output logic [SIDE_W-1:0]   side_o
);
   localparam int REM_W = ROOT_W + 2;

   logic                valid_ff;
   logic [REM_W-1:0]    rem_ff, rem_in;
   logic [ROOT_W-1:0]   root_ff, root_in;
   logic [RAD_W-1:0]    rad_ff;
   logic [SIDE_W-1:0]   side_ff;
   logic [REM_W+1:0]    cur;
   logic [REM_W+1:0]    trial;

   always_comb begin
      cur   = {rem_i, rad_i[RAD_W-1 -: 2]};
      trial = (REM_W+2)'({root_i, 2'b01});
      if (cur >= trial) begin
         rem_in  = REM_W'(cur - trial);
         root_in = {root_i[ROOT_W-2:0], 1'b1};
      end else begin
         rem_in  = REM_W'(cur);
         root_in = {root_i[ROOT_W-2:0], 1'b0};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_i;
      end
      rem_ff  <= rem_in;
      root_ff <= root_in;
      rad_ff  <= {rad_i[RAD_W-3:0], 2'b00};
      side_ff <= side_i;
   end

   assign valid_o = valid_ff;
   assign rem_o   = rem_ff;
   assign root_o  = root_ff;
   assign rad_o   = rad_ff;
   assign side_o  = side_ff;
endmodule

// ----- hw/rtl/rdz_div_cell.sv -----
// One quotient-bit cell of the three-lane restoring divider chain.
module rdz_div_cell #(
   parameter int DIV_W  = 25,
   parameter int SIDE_W = 4
) (
   input  logic                                    clock,
   input  logic                                    reset,
   input  logic                                    valid_i,
   input  logic [rdz_pkg::LANES-1:0][DIV_W-1:0]    rem_i,
   input  logic [rdz_pkg::LANES-1:0][DIV_W-1:0]    den_i,
   input  logic [rdz_pkg::LANES-1:0][rdz_pkg::Q_W-1:0] nlow_i,
   input  logic [rdz_pkg::LANES-1:0][rdz_pkg::Q_W-1:0] quo_i,
   input  logic [SIDE_W-1:0]                       side_i,
   output logic                                    valid_o,
   output logic [rdz_pkg::LANES-1:0][DIV_W-1:0]    rem_o,
   output logic [rdz_pkg::LANES-1:0][DIV_W-1:0]    den_o,
   output logic [rdz_pkg::LANES-1:0][rdz_pkg::Q_W-1:0] nlow_o,
   output logic [rdz_pkg::LANES-1:0][rdz_pkg::Q_W-1:0] quo_o,
   output logic [SIDE_W-1:0]                       side_o
);
   import rdz_pkg::*;

   logic                          valid_ff;
   logic [LANES-1:0][DIV_W-1:0]   rem_ff, rem_in;
   logic [LANES-1:0][DIV_W-1:0]   den_ff;
   logic [LANES-1:0][Q_W-1:0]     nlow_ff;
   logic [LANES-1:0][Q_W-1:0]     quo_ff, quo_in;
   logic [SIDE_W-1:0]             side_ff;
   logic [LANES-1:0][DIV_W:0]     cur;
   logic [LANES-1:0]              ge;

   always_comb begin
      for (int l = 0; l < LANES; l++) begin
         cur[l]    = {rem_i[l], nlow_i[l][Q_W-1]};
         ge[l]     = cur[l] >= {1'b0, den_i[l]};
         rem_in[l] = ge[l] ? DIV_W'(cur[l] - {1'b0, den_i[l]}) : DIV_W'(cur[l]);
         quo_in[l] = {quo_i[l][Q_W-2:0], ge[l]};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_i;
      end
      rem_ff  <= rem_in;
      den_ff  <= den_i;
      quo_ff  <= quo_in;
      side_ff <= side_i;
      for (int l = 0; l < LANES; l++) begin
         nlow_ff[l] <= {nlow_i[l][Q_W-2:0], 1'b0};
      end
   end

   assign valid_o = valid_ff;
   assign rem_o   = rem_ff;
   assign den_o   = den_ff;
   assign nlow_o  = nlow_ff;
   assign quo_o   = quo_ff;
   assign side_o  = side_ff;
endmodule

// ----- sim/tb_top.sv -----
// Self-checking testbench for the radial dead-zone stick block.
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;
   import rdz_pkg::*;

   localparam int LATENCY = 46;
   localparam int FS = 32767;
   localparam longint CYCLE_LIMIT = 400000;

   class stick_scoreboard;
      rsp_type pending[$];
      logic [14:0] zone;
      int errors;

      function new();
         zone = DZ_RESET;
         errors = 0;
      endfunction

      function longint unsigned root(longint unsigned v);
         longint unsigned r, b;
         r = 0;
         b = 64'd1 << 62;
         while (b > v) b = b >> 2;
         while (b != 0) begin
            if (v >= r + b) begin
               v = v - (r + b);
               r = (r >> 1) + b;
            end else begin
               r = r >> 1;
            end
            b = b >> 2;
         end
         return r;
      endfunction

      function logic [15:0] unit_dir(longint v, longint unsigned mq);
         longint unsigned a, q;
         a = (v < 0) ? -v : v;
         q = ((a << 24) + mq) / (2 * mq);
         if (v < 0) begin
            if (q > 32768) q = 32768;
            return 16'(-q);
         end
         if (q > 32767) q = 32767;
         return 16'(q);
      endfunction

      function void note_sample(req_type r);
         rsp_type e;
         longint x, y;
         longint unsigned s, dz, mq, mc, num, den, q;
         x = r.stick_x;
         y = r.stick_y;
         s = x * x + y * y;
         dz = zone;
         e = '0;
         if (s > dz * dz) begin
            mq = root(s << 16);
            e.direction_x = unit_dir(x, mq);
            e.direction_y = unit_dir(y, mq);
            if (dz >= FS) begin
               e.scaled_magnitude = MAG_ONE;
            end else begin
               mc = (mq > (FS << 8)) ? (FS << 8) : mq;
               num = mc - (dz << 8);
               den = (FS - dz) << 8;
               q = ((num << 16) + den) / (2 * den);
               e.scaled_magnitude = (q > 32768) ? 16'd32768 : 16'(q);
            end
            e.outside_zone = 1'b1;
         end
         pending.push_back(e);
      endfunction

      function void check_result(rsp_type a);
         rsp_type e;
         if (pending.size() == 0) begin
            $error("unexpected result %h", a);
            errors++;
            return;
         end
         e = pending.pop_front();
         if (a.direction_x !== e.direction_x) begin
            $error("direction_x exp %0d got %0d", e.direction_x, a.direction_x); errors++;
         end
         if (a.direction_y !== e.direction_y) begin
            $error("direction_y exp %0d got %0d", e.direction_y, a.direction_y); errors++;
         end
         if (a.scaled_magnitude !== e.scaled_magnitude) begin
            $error("scaled_magnitude exp %0d got %0d", e.scaled_magnitude,
                   a.scaled_magnitude); errors++;
         end
         if (a.outside_zone !== e.outside_zone) begin
            $error("outside_zone exp %0b got %0b", e.outside_zone, a.outside_zone); errors++;
         end
      endfunction
   endclass

   logic clock = 0, reset = 1, start = 0, csr_we = 0;
   logic busy, rsp_valid;
   logic [DZ_W-1:0] csr_wdata = '0;
   req_type req_data = '0;
   rsp_type rsp_data;
   longint cycles = 0;
   stick_scoreboard board = new();

   radial_dead_zone_stick dut (
      .clock(clock), .reset(reset), .start(start), .busy(busy), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_data(rsp_data), .csr_we(csr_we), .csr_wdata(csr_wdata)
   );

   always #5 clock = ~clock;

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (!reset && rsp_valid) board.check_result(rsp_data);
      if (cycles > CYCLE_LIMIT) begin
         $display("radial_dead_zone_stick test failed");
         $finish;
      end
   end

   // start stays high between back-to-back transactions and drops only for a gap
   task automatic send_sample(logic signed [15:0] x, logic signed [15:0] y, bit gaps);
      int gap;
      gap = gaps ? $urandom_range(0, 7) : 0;
      if (gap != 0) begin
         start <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_data <= '{stick_x: x, stick_y: y};
      start <= 1'b1;
      @(posedge clock);
      while (busy) @(posedge clock);
      board.note_sample(req_data);
      @(negedge clock);
   endtask

   task automatic drain();
      start <= 1'b0;
      while (board.pending.size() != 0) @(negedge clock);
      repeat (LATENCY + 4) @(negedge clock);
   endtask

   task automatic set_zone(logic [14:0] v);
      csr_wdata <= v;
      csr_we <= 1'b1;
      @(negedge clock);
      csr_we <= 1'b0;
      board.zone = v;
   endtask

   task automatic random_sample(bit gaps);
      int k;
      logic signed [15:0] x, y;
      k = $urandom_range(0, 9);
      x = 16'($urandom);
      y = 16'($urandom);
      if (k < 3) begin
         x = $signed(16'($urandom_range(0, 2 * board.zone + 2))) - $signed({1'b0, board.zone});
         y = $signed(16'($urandom_range(0, 2 * board.zone + 2))) - $signed({1'b0, board.zone});
      end else if (k == 3) begin
         x = $urandom_range(0, 1) ? -16'sd32768 : 16'sd32767;
      end
      send_sample(x, y, gaps);
   endtask

   logic [14:0] zones[6] = '{15'd0, 15'd1, 15'd32766, 15'd16384, 15'd32767, 15'd100};

   initial begin
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      // directed: extremes, zone boundary, corners, axes
      send_sample(16'sd0, 16'sd0, 1'b1);
      send_sample(16'sd7849, 16'sd0, 1'b1);
      send_sample(16'sd7850, 16'sd0, 1'b1);
      send_sample(-16'sd7849, 16'sd0, 1'b0);
      send_sample(16'sd0, -16'sd7850, 1'b0);
      send_sample(16'sd32767, 16'sd32767, 1'b0);
      send_sample(-16'sd32768, -16'sd32768, 1'b0);
      send_sample(-16'sd32768, 16'sd0, 1'b1);
      send_sample(16'sd32767, 16'sd0, 1'b1);
      send_sample(16'sd0, -16'sd32768, 1'b1);
      send_sample(-16'sd32768, 16'sd32767, 1'b1);
      send_sample(16'sd5000, 16'sd6000, 1'b1);
      send_sample(-16'sd1, 16'sd1, 1'b1);
      drain();
      foreach (zones[i]) begin
         set_zone(zones[i]);
         send_sample(16'sd32767, 16'sd0, 1'b1);
         send_sample(-16'sd32768, -16'sd32768, 1'b1);
         send_sample($signed({1'b0, zones[i]}), 16'sd0, 1'b1);
         for (int n = 0; n < 200; n++) random_sample($urandom_range(0, 3) != 0);
         drain();
      end
      set_zone(15'($urandom_range(0, 32766)));
      for (int n = 0; n < 100; n++) random_sample(n < 50);
      drain();
      if (board.errors == 0)
         $display("radial_dead_zone_stick test passed");
      else
         $display("radial_dead_zone_stick test failed");
      $finish;
   end
endmodule
